@@ rtl/lkwd_pkg.sv @@
package lkwd_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned WORD_W = 16;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    key_t  key;
    word_t cipher;
  } key_beat_t;

  function automatic word_t keystream(input key_t k);
    logic [31:0] x;
    logic [31:0] v;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] sum;
    x = k ^ (k >> 1);
    v = (((k >> 15) & 32'h0000_2000) | (k & 32'h0100_0000)) >> 1;
    v = (v | (k & 32'h0002_0000)) >> 2;
    v = (v | (k & 32'h0000_1000)) >> 3;
    v = (v | (((k >> 7) ^ k) & 32'h0008_0000)) >> 1;
    v = (v | (((k >> 15) ^ k) & 32'h0000_4000)) >> 2;
    v = (v | (k & 32'h0000_2000)) >> 2;
    v = (v | (x & 32'h0000_0040) | (k & 32'h0000_0020)) >> 1;
    v = v | (((k >> 9) ^ (k << 8)) & 32'h0000_0800);
    v = v | (((k >> 20) ^ (k << 1)) & 32'h0000_0004);
    v = v | (((k << 3) ^ (k >> 16)) & 32'h0000_4000);
    v = v | (((k >> 2) ^ (k >> 16)) & 32'h0000_0080);
    v = v | (((k << 6) ^ (k >> 7)) & 32'h0000_0100);
    v = v | ((k & 32'h0000_0100) << 7);
    hi  = (v >> 8) & 32'h0000_FFFF;
    lo  = ((v & 32'h0000_00FF) | (k & 32'h0000_0001)) << 8;
    sum = hi + lo;
    return sum[WORD_W-1:0];
  endfunction

  function automatic key_t advance_key(input key_t k);
    logic fb;
    fb = k[0] ^ k[10] ^ k[30] ^ k[31];
    return {fb, k[KEY_W-1:1]};
  endfunction

endpackage

@@ rtl/lkwd_in_if.sv @@
interface lkwd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      start_of_message;
  logic [lkwd_pkg::WORD_W-1:0] cipher_word;

  modport source(output valid, output start_of_message, output cipher_word, input ready);
  modport sink(input valid, input start_of_message, input cipher_word, output ready);
endinterface

@@ rtl/lkwd_out_if.sv @@
interface lkwd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lkwd_pkg::WORD_W-1:0] plain_word;

  modport source(output valid, output plain_word, input ready);
  modport sink(input valid, input plain_word, output ready);
endinterface

@@ rtl/lfsr_keystream_word_decrypt_top.sv @@
// channel | direction | payload                          | handshake
// in_bus  | in        | start_of_message, cipher_word    | valid/ready
// out_bus | out       | plain_word                       | valid/ready
// cfg     | in        | cfg_wr_data (initial key)        | cfg_wr_en
//
// An input beat passes the stage register, then the result register; one word per cycle when out_bus is not stalled.
// The key register advances as the input beat is taken; the keystream network
// and XOR sit between the stage register and the result register.
// Synchronous active-low reset clears the keys and both valid flags.
// A stall at the output backs up through the stage register to in_bus.ready.
module lfsr_keystream_word_decrypt_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  lkwd_pkg::key_t cfg_wr_data,
  lkwd_in_if.sink        in_bus,
  lkwd_out_if.source     out_bus
);
  import lkwd_pkg::*;

  logic      st_valid;
  logic      st_ready;
  key_beat_t st_beat;

  lkwd_key u_key (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_bus      (in_bus),
    .st_valid    (st_valid),
    .st_beat     (st_beat),
    .st_ready    (st_ready)
  );

  lkwd_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .st_valid (st_valid),
    .st_beat  (st_beat),
    .st_ready (st_ready),
    .out_bus  (out_bus)
  );
endmodule

@@ rtl/lkwd_key.sv @@
module lkwd_key (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  lkwd_pkg::key_t      cfg_wr_data,
  lkwd_in_if.sink             in_bus,
  output logic                st_valid,
  output lkwd_pkg::key_beat_t st_beat,
  input  logic                st_ready
);
  import lkwd_pkg::*;

  key_t      initial_key_r;
  key_t      running_key_r;
  key_t      running_key_nxt;
  key_t      key_used;
  logic      vld_r;
  logic      vld_nxt;
  key_beat_t beat_r;
  key_beat_t beat_nxt;
  logic      accept;

  assign in_bus.ready = !vld_r || st_ready;
  assign accept       = in_bus.valid && in_bus.ready;
  assign key_used     = in_bus.start_of_message ? initial_key_r : running_key_r;

  always_comb begin
    running_key_nxt = running_key_r;
    vld_nxt         = vld_r;
    beat_nxt        = beat_r;
    if (st_ready) begin
      vld_nxt = 1'b0;
    end
    if (accept) begin
      running_key_nxt = advance_key(key_used);
      vld_nxt         = 1'b1;
      beat_nxt.key    = key_used;
      beat_nxt.cipher = in_bus.cipher_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_key_r <= '0;
      running_key_r <= '0;
      vld_r         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        initial_key_r <= cfg_wr_data;
      end
      running_key_r <= running_key_nxt;
      vld_r         <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign st_valid = vld_r;
  assign st_beat  = beat_r;

  a_start_loads_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_bus.start_of_message) |=> (beat_r.key == $past(initial_key_r)))
    else $error("start beat did not use the seed key");

  a_key_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> (running_key_r == $past(running_key_r)))
    else $error("running key moved without a beat");

  a_key_advances: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (running_key_r == advance_key(beat_r.key)))
    else $error("running key did not advance from the used key");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !st_ready) |=> (vld_r && $stable(beat_r)))
    else $error("stage beat lost under stall");
endmodule

@@ rtl/lkwd_out.sv @@
module lkwd_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                st_valid,
  input  lkwd_pkg::key_beat_t st_beat,
  output logic                st_ready,
  lkwd_out_if.source          out_bus
);
  import lkwd_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  word_t plain_r;
  word_t plain_nxt;
  logic  take;

  assign st_ready = !vld_r || out_bus.ready;
  assign take     = st_valid && st_ready;

  always_comb begin
    vld_nxt   = vld_r;
    plain_nxt = plain_r;
    if (out_bus.ready) begin
      vld_nxt = 1'b0;
    end
    if (take) begin
      vld_nxt   = 1'b1;
      plain_nxt = st_beat.cipher ^ keystream(st_beat.key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plain_r <= plain_nxt;
  end

  assign out_bus.valid      = vld_r;
  assign out_bus.plain_word = plain_r;

  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (vld_r &&
              plain_r == ($past(st_beat.cipher) ^ keystream($past(st_beat.key)))))
    else $error("result word does not match its stage beat");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r |-> st_ready)
    else $error("empty result register refused a beat");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_bus.ready) |=> vld_r)
    else $error("result beat dropped while stalled");
endmodule

@@ test/lfsr_keystream_word_decrypt_top_test.sv @@
module lfsr_keystream_word_decrypt_top_test;
  import lkwd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_STALL  = 60;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_WORDS = 75;

  typedef enum int unsigned {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_COIN,
    RX_PATTERN
  } rx_mode_e;

  class word_decrypt_scoreboard;
    key_t        seed_key;
    key_t        live_key;
    word_t       plain_expect_q[$];
    int unsigned mismatch_count;
    int unsigned words_checked;
    int unsigned message_starts;

    function new();
      seed_key       = '0;
      live_key       = '0;
      mismatch_count = 0;
      words_checked  = 0;
      message_starts = 0;
    endfunction

    function word_t keystream_from_key(key_t k);
      logic [31:0] kx;
      logic [31:0] acc;
      logic [31:0] hi;
      logic [31:0] lo;
      logic [31:0] sum;
      kx  = k ^ (k >> 1);
      acc = (((k >> 15) & 32'h0000_2000) | (k & 32'h0100_0000)) >> 1;
      acc = (acc | (k & 32'h0002_0000)) >> 2;
      acc = (acc | (k & 32'h0000_1000)) >> 3;
      acc = (acc | (((k >> 7) ^ k) & 32'h0008_0000)) >> 1;
      acc = (acc | (((k >> 15) ^ k) & 32'h0000_4000)) >> 2;
      acc = (acc | (k & 32'h0000_2000)) >> 2;
      acc = (acc | (kx & 32'h0000_0040) | (k & 32'h0000_0020)) >> 1;
      acc = acc | (((k >> 9) ^ (k << 8)) & 32'h0000_0800);
      acc = acc | (((k >> 20) ^ (k << 1)) & 32'h0000_0004);
      acc = acc | (((k << 3) ^ (k >> 16)) & 32'h0000_4000);
      acc = acc | (((k >> 2) ^ (k >> 16)) & 32'h0000_0080);
      acc = acc | (((k << 6) ^ (k >> 7)) & 32'h0000_0100);
      acc = acc | ((k & 32'h0000_0100) << 7);
      hi  = (acc >> 8) & 32'h0000_FFFF;
      lo  = ((acc & 32'h0000_00FF) | (k & 32'h0000_0001)) << 8;
      sum = hi + lo;
      return sum[WORD_W-1:0];
    endfunction

    function key_t key_after_step(key_t k);
      logic [31:0] kx;
      logic [31:0] tap;
      kx  = k ^ (k >> 1);
      tap = (k ^ (((kx >> 20) ^ k) >> 10)) & 32'h1;
      return (tap << 31) | (k >> 1);
    endfunction

    function void flag(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void note_cipher_word(logic som, word_t cw);
      if (som) begin
        live_key = seed_key;
        message_starts++;
      end
      plain_expect_q.push_back(cw ^ keystream_from_key(live_key));
      live_key = key_after_step(live_key);
    endfunction

    function void check_plain_word(word_t got);
      word_t want;
      if (plain_expect_q.size() == 0) begin
        flag($sformatf("plain_word %h arrived with nothing outstanding", got));
      end else begin
        want = plain_expect_q.pop_front();
        words_checked++;
        if (got !== want) begin
          flag($sformatf("plain_word mismatch: expected %h got %h", want, got));
        end
      end
    endfunction

    function int unsigned pending();
      return plain_expect_q.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_wr_en;
  key_t  cfg_wr_data;

  lkwd_in_if  in_ch();
  lkwd_out_if out_ch();

  word_decrypt_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned burst_left;
  int unsigned settings_used;
  logic        long_stall_req = 1'b0;

  lfsr_keystream_word_decrypt_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_bus      (in_ch),
    .out_bus     (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_cipher_word(in_ch.start_of_message, in_ch.cipher_word);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_plain_word(out_ch.plain_word);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rx_mode_e    mode;
    int unsigned left;
    int unsigned ph;
    int unsigned n;
    logic [7:0]  pat;
    out_ch.ready <= 1'b0;
    mode = RX_ALWAYS;
    left = 0;
    ph   = 0;
    pat  = 8'hFF;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (n = 0; n < LONG_STALL; n++) begin
          @(posedge clk);
        end
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          pat  = 8'($urandom);
          left = $urandom_range(20, 80);
        end
        left--;
        case (mode)
          RX_ALWAYS: begin
            out_ch.ready <= 1'b1;
          end
          RX_MOSTLY: begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
          end
          RX_COIN: begin
            out_ch.ready <= ($urandom_range(0, 1) != 0);
          end
          default: begin
            out_ch.ready <= pat[ph % 8];
            ph++;
          end
        endcase
      end
    end
  end

  task automatic offer_word(input logic som, input word_t cw);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid            <= 1'b1;
    in_ch.start_of_message <= som;
    in_ch.cipher_word      <= cw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_seed(input key_t k);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.seed_key = k;
    settings_used++;
  endtask

  task automatic run_messages(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned i;
    logic        som;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      for (i = 0; i < len && sent < count; i++) begin
        if (i == 0) begin
          som = ($urandom_range(0, 7) != 0);
        end else begin
          som = ($urandom_range(0, 29) == 0);
        end
        offer_word(som, word_t'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned phase;
    key_t        k;
    rst_n                  <= 1'b0;
    cfg_wr_en              <= 1'b0;
    cfg_wr_data            <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.start_of_message <= 1'b0;
    in_ch.cipher_word      <= '0;
    burst_left    = 0;
    settings_used = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no start yet: running key is the zero left by reset
    offer_word(1'b0, 16'h0000);
    offer_word(1'b0, 16'hFFFF);
    offer_word(1'b0, 16'h5A5A);
    drain();

    load_seed(32'hFFFF_FFFF);
    offer_word(1'b1, 16'hFFFF);
    offer_word(1'b0, 16'h0000);
    offer_word(1'b0, 16'hAAAA);
    offer_word(1'b0, 16'h5555);
    offer_word(1'b0, 16'h8001);
    offer_word(1'b1, 16'h7FFE);
    offer_word(1'b0, 16'h0001);
    drain();

    load_seed(32'h0000_0000);
    offer_word(1'b1, 16'h1234);
    offer_word(1'b0, 16'hFEDC);
    offer_word(1'b1, 16'h0000);
    drain();

    load_seed(32'h8000_0001);
    offer_word(1'b1, 16'h8000);
    offer_word(1'b0, 16'h00FF);
    offer_word(1'b0, 16'hFF00);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 1) begin
        k = 32'hFFFF_FFFF;
      end else if (phase == 4) begin
        k = 32'h0000_0000;
      end else begin
        k = $urandom;
      end
      load_seed(k);
      if (phase == 2) begin
        // hold the sink off and keep offering so the pipe backs up
        long_stall_req = 1'b1;
        burst_left     = 48;
      end
      run_messages(PHASE_WORDS);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("run covered %0d plain words under %0d initial keys, %0d message starts",
             sb.words_checked, settings_used, sb.message_starts);
    $display("%0d mismatches, %0d words still outstanding", sb.mismatch_count, sb.pending());
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lkwd_pkg.sv
rtl/lkwd_in_if.sv
rtl/lkwd_out_if.sv
rtl/lkwd_key.sv
rtl/lkwd_out.sv
rtl/lfsr_keystream_word_decrypt_top.sv
test/lfsr_keystream_word_decrypt_top_test.sv
